// File: hw/rtl/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder: code points, byte limits,
// the lead byte classes and the record that moves from decoder to serializer.
// Depends on nothing.
package u8u16_pkg;

  // UTF-16 constants.
  localparam logic [15:0] UNIT_REPL     = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;
  localparam logic [9:0]  SURR_PAYLOAD  = 10'h3FF;

  // UTF-8 byte limits.
  localparam logic [7:0] ASCII_END     = 8'h80;
  localparam logic [7:0] LEAD2_MIN     = 8'hC2;
  localparam logic [7:0] LEAD2_MAX     = 8'hDF;
  localparam logic [7:0] LEAD3_MIN     = 8'hE0;
  localparam logic [7:0] LEAD3_MAX     = 8'hEF;
  localparam logic [7:0] LEAD4_MIN     = 8'hF0;
  localparam logic [7:0] LEAD4_MAX     = 8'hF4;
  localparam logic [7:0] LEAD_E0       = 8'hE0;
  localparam logic [7:0] LEAD_ED       = 8'hED;
  localparam logic [7:0] LEAD_F0       = 8'hF0;
  localparam logic [7:0] LEAD_F4       = 8'hF4;
  localparam logic [7:0] CONT_MIN      = 8'h80;
  localparam logic [7:0] CONT_MAX      = 8'hBF;
  localparam logic [7:0] CONT_MIN_E0   = 8'hA0;
  localparam logic [7:0] CONT_MAX_ED   = 8'h9F;
  localparam logic [7:0] CONT_MIN_F0   = 8'h90;
  localparam logic [7:0] CONT_MAX_F4   = 8'h8F;

  // Most units one byte can cause, and the width of a unit count.
  localparam int UNITS_MAX = 4;
  localparam int CNT_W     = 3;

  // Default depth of the queue between decoder and serializer.
  localparam int Q_DEPTH_DEFAULT = 2;

  // Class of a byte taken as a lead.
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  // All units caused by one input byte.
  typedef struct packed {
    logic [UNITS_MAX-1:0][15:0] units;
    logic [CNT_W-1:0]           cnt;
    logic                       fin;
  } job_t;

endpackage

// File: hw/rtl/u8u16_if.sv
// Channel interfaces of the transcoder: the byte input and the unit output.
// Each carries valid, ready and the payload. Depends on nothing.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source(output valid, in_byte, is_final, input ready);
  modport sink(input valid, in_byte, is_final, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_end;
  logic        string_end;

  modport source(output valid, code_unit, run_end, string_end, input ready);
  modport sink(input valid, code_unit, run_end, string_end, output ready);
endinterface

// File: hw/rtl/u8u16_front.sv
// Decoder front end: accepts UTF-8 bytes, tracks the open sequence and
// turns each byte into at most one UTF-16 unit record. Uses u8u16_pkg, u8u16_in_if.
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  u8u16_in_if.sink     rx,
  output job_t         job,
  output logic         job_valid,
  input  logic         job_ready
);

  // Decoder state.
  logic [1:0]  seq_length, seq_length_next;
  logic [1:0]  bytes_taken, bytes_taken_next;
  logic [14:0] partial_point, partial_point_next;
  logic [7:0]  lead_value, lead_value_next;

  logic        accept;
  logic [7:0]  b;
  logic        open_seq;
  logic [7:0]  lo_lim;
  logic [7:0]  hi_lim;
  logic        cont_ok;
  logic [20:0] point;
  logic [20:0] supp_off;
  logic [1:0]  taken_inc;
  logic        complete;
  lead_kind_t  kind;
  logic [1:0]  lead_len;
  logic [14:0] lead_bits;
  logic [15:0] lead_unit;
  logic [1:0]  n_pre;
  logic [1:0]  n_mid;
  logic [1:0]  n_post;
  logic [15:0] u0;
  logic [15:0] u1;
  logic [CNT_W-1:0] mid_end;

  assign accept   = rx.valid && rx.ready;
  assign rx.ready = job_ready;
  assign b        = rx.in_byte;

  // Classify the byte as a lead.
  always_comb begin
    lead_len  = 2'd0;
    lead_bits = '0;
    lead_unit = UNIT_REPL;
    if (b < ASCII_END) begin
      kind      = LEAD_ASCII;
      lead_unit = {8'h00, b};
    end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      kind      = LEAD_TWO;
      lead_len  = 2'd1;
      lead_bits = {10'd0, b[4:0]};
    end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
      kind      = LEAD_THREE;
      lead_len  = 2'd2;
      lead_bits = {11'd0, b[3:0]};
    end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      kind      = LEAD_FOUR;
      lead_len  = 2'd3;
      lead_bits = {12'd0, b[2:0]};
    end else begin
      kind      = LEAD_BAD;
    end
  end

  // Continuation check; the first continuation has tighter limits after
  // some leads, which rules out overlong forms, surrogates and values
  // above the last plane.
  always_comb begin
    lo_lim = CONT_MIN;
    hi_lim = CONT_MAX;
    if (bytes_taken == 2'd0) begin
      if (lead_value == LEAD_E0) begin
        lo_lim = CONT_MIN_E0;
      end else if (lead_value == LEAD_ED) begin
        hi_lim = CONT_MAX_ED;
      end else if (lead_value == LEAD_F0) begin
        lo_lim = CONT_MIN_F0;
      end else if (lead_value == LEAD_F4) begin
        hi_lim = CONT_MAX_F4;
      end
    end
    cont_ok = (b >= lo_lim) && (b <= hi_lim);
  end

  assign open_seq  = (seq_length != 2'd0);
  assign point     = {partial_point, b[5:0]};
  assign supp_off  = point - SUPP_BASE;
  assign taken_inc = bytes_taken + 2'd1;
  assign complete  = (taken_inc == seq_length);

  // Units of one byte: n_pre replacements for a broken sequence, then n_mid
  // units from the lead or the finished point, then n_post replacements for
  // a sequence cut short by the end of the string.
  always_comb begin
    seq_length_next    = seq_length;
    bytes_taken_next   = bytes_taken;
    partial_point_next = partial_point;
    lead_value_next    = lead_value;
    n_pre  = 2'd0;
    n_mid  = 2'd0;
    n_post = 2'd0;
    u0     = UNIT_REPL;
    u1     = UNIT_REPL;
    if (open_seq && cont_ok) begin
      if (complete) begin
        if (point[20:16] == 5'd0) begin
          n_mid = 2'd1;
          u0    = point[15:0];
        end else begin
          n_mid = 2'd2;
          u0    = HI_SURR_BASE | {6'd0, supp_off[19:10]};
          u1    = LO_SURR_BASE | {6'd0, supp_off[9:0] & SURR_PAYLOAD};
        end
        seq_length_next    = 2'd0;
        bytes_taken_next   = 2'd0;
        partial_point_next = '0;
        lead_value_next    = '0;
      end else if (rx.is_final) begin
        n_post             = taken_inc + 2'd1;
        seq_length_next    = 2'd0;
        bytes_taken_next   = 2'd0;
        partial_point_next = '0;
        lead_value_next    = '0;
      end else begin
        bytes_taken_next   = taken_inc;
        partial_point_next = point[14:0];
      end
    end else begin
      // A broken sequence gives one replacement per byte consumed.
      if (open_seq) begin
        n_pre = bytes_taken + 2'd1;
      end
      seq_length_next    = 2'd0;
      bytes_taken_next   = 2'd0;
      partial_point_next = '0;
      lead_value_next    = '0;
      unique case (kind)
        LEAD_ASCII, LEAD_BAD: begin
          n_mid = 2'd1;
          u0    = lead_unit;
        end
        LEAD_TWO, LEAD_THREE, LEAD_FOUR: begin
          if (rx.is_final) begin
            n_post = 2'd1;
          end else begin
            seq_length_next    = lead_len;
            partial_point_next = lead_bits;
            lead_value_next    = b;
          end
        end
        default: begin
          n_mid = 2'd1;
        end
      endcase
    end
  end

  // Assemble the record.
  assign mid_end = CNT_W'(n_pre) + CNT_W'(n_mid);

  always_comb begin
    job.cnt = mid_end + CNT_W'(n_post);
    job.fin = rx.is_final;
    for (int k = 0; k < UNITS_MAX; k++) begin
      if (CNT_W'(k) >= CNT_W'(n_pre) && CNT_W'(k) < mid_end) begin
        job.units[k] = (CNT_W'(k) == CNT_W'(n_pre)) ? u0 : u1;
      end else begin
        job.units[k] = UNIT_REPL;
      end
    end
  end

  // A byte that leaves a sequence pending causes no record.
  assign job_valid = accept && (job.cnt != '0);

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length    <= 2'd0;
      bytes_taken   <= 2'd0;
      partial_point <= '0;
      lead_value    <= '0;
    end else if (accept) begin
      seq_length    <= seq_length_next;
      bytes_taken   <= bytes_taken_next;
      partial_point <= partial_point_next;
      lead_value    <= lead_value_next;
    end
  end

endmodule

// File: hw/rtl/u8u16_queue.sv
// Short queue of unit records between the decoder and the serializer,
// so that each side stalls on its own. Uses u8u16_pkg.
module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  job_t push_job,
  input  logic push_valid,
  output logic push_ready,
  output job_t pop_job,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_Q = $clog2(DEPTH + 1);

  job_t             store [DEPTH];
  logic [PTR_W-1:0] wptr, wptr_next;
  logic [PTR_W-1:0] rptr, rptr_next;
  logic [CNT_Q-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_Q'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = store[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer wrap for any depth.
  assign wptr_next = (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
  assign rptr_next = (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr_next;
      end
      if (pop) begin
        rptr <= rptr_next;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/u8u16_back.sv
// Serializer back end: holds one record and sends its units one per word
// on the output channel, marking run and string ends. Uses u8u16_pkg.
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  job_t         job,
  input  logic         job_valid,
  output logic         job_ready,
  u8u16_out_if.source  tx
);

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       last;
  logic       fire;
  logic       load;

  // Current word.
  assign last          = ({1'b0, idx} == (cur.cnt - 1'b1));
  assign tx.valid      = busy;
  assign tx.code_unit  = cur.units[idx];
  assign tx.run_end    = last;
  assign tx.string_end = last && cur.fin;

  assign fire      = tx.valid && tx.ready;
  assign job_ready = !busy || (fire && last);
  assign load      = job_ready && job_valid;

  // Record register, loaded when idle or as the last word leaves.
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= job;
    end
  end

  // Occupancy and unit index.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (fire) begin
      if (last) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/utf8_to_utf16_transcoder.sv
// Strict UTF-8 to UTF-16 transcoder, top level.
// Input channel rx carries one byte per word with is_final on the last byte
// of a string. Output channel tx carries one UTF-16 code unit per word;
// run_end marks the last unit caused by an input byte and string_end the
// last unit of the string. Invalid input gives one U+FFFD per consumed byte.
// A byte that leaves a multi-byte sequence pending gives no word.
// After a byte is accepted, its record passes through the queue and then the
// output register before the first unit of the byte is offered on tx.
// Throughput: one byte per cycle while tx does not stall and each byte causes
// at most one unit; a byte that causes n units (up to four) holds the output
// register for n words; the queue of QUEUE_DEPTH records absorbs that before
// rx.ready drops. When tx stalls, the current word holds and the queue fills.
// Reset closes any open sequence and empties the queue and output register.
// Uses u8u16_pkg, u8u16_if, u8u16_front, u8u16_queue and u8u16_back.
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
#(
  parameter int QUEUE_DEPTH = Q_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  u8u16_in_if.sink    rx,
  u8u16_out_if.source tx
);

  job_t fj;
  logic fj_valid;
  logic fj_ready;
  job_t qj;
  logic qj_valid;
  logic qj_ready;

  // Decoder.
  u8u16_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .job       (fj),
    .job_valid (fj_valid),
    .job_ready (fj_ready)
  );

  // Record queue.
  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (fj),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .pop_job    (qj),
    .pop_valid  (qj_valid),
    .pop_ready  (qj_ready)
  );

  // Serializer.
  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (qj),
    .job_valid (qj_valid),
    .job_ready (qj_ready),
    .tx        (tx)
  );

`ifndef SYNTHESIS
  // A record enters the queue only when there is room for it.
  assert property (@(posedge clk) disable iff (rst) fj_valid |-> fj_ready)
    else $error("record pushed into a full queue");

  // Every record holds between one and four units.
  assert property (@(posedge clk) disable iff (rst)
    qj_valid |-> (qj.cnt != '0) && (qj.cnt <= CNT_W'(UNITS_MAX)))
    else $error("queued record with a bad unit count");

  // The end of a string is always the end of a run.
  assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.string_end |-> tx.run_end)
    else $error("string end without run end");
`endif

endmodule
